FILE: hw/rtl/v3au_pkg.sv
// Package: types, constants and command codes for the vector arithmetic unit.
`default_nettype none
package v3au_pkg;
  localparam int CompWidth = 32;
  localparam int FracBits  = 16;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_DOT   = 3'd2,
    CMD_CROSS = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_LEN   = 3'd5
  } cmd_e;

  localparam logic [1:0] KIND_VEC = 2'd0;
  localparam logic [1:0] KIND_SCL = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef struct packed {
    logic [2:0]                command;
    logic signed [CompWidth-1:0] a_x;
    logic signed [CompWidth-1:0] a_y;
    logic signed [CompWidth-1:0] a_z;
    logic signed [CompWidth-1:0] b_x;
    logic signed [CompWidth-1:0] b_y;
    logic signed [CompWidth-1:0] b_z;
    logic signed [CompWidth-1:0] scale_factor;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                result_kind;
    logic signed [CompWidth-1:0] res_x;
    logic signed [CompWidth-1:0] res_y;
    logic signed [CompWidth-1:0] res_z;
    logic signed [CompWidth-1:0] res_scalar;
  } out_item_t;
endpackage
`default_nettype wire

FILE: hw/rtl/v3au_lane.sv
// Lane: two signed products of two operand pairs, registered.
`default_nettype none
module v3au_lane import v3au_pkg::*; #(
  parameter int W = CompWidth
) (
  input  wire                    clk,
  input  wire                    en,
  input  wire logic signed [W-1:0] p0,
  input  wire logic signed [W-1:0] q0,
  input  wire logic signed [W-1:0] p1,
  input  wire logic signed [W-1:0] q1,
  output logic signed [2*W-1:0]  m0,
  output logic signed [2*W-1:0]  m1
);
  // one multiplier pair per lane
  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= p0 * q0;
      m1 <= p1 * q1;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/v3au_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module v3au_isqrt #(
  parameter int NW = 68,
  parameter int RW = 34
) (
  input  wire           clk,
  input  wire           en,
  input  wire [NW-1:0]  num,
  output logic [RW-1:0] root
);
  logic [NW-1:0] rem [RW+1];
  logic [RW-1:0] rt  [RW+1];

  assign rem[0] = num;
  assign rt[0]  = '0;

  // stage k decides bit RW-1-k
  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int B = RW - 1 - k;
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_q;
    logic [RW-1:0] rt_q;
    always_comb begin
      trial = (NW'(rt[k]) << (B + 1)) + (NW'(1) << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem_q <= rem[k] - trial;
          rt_q  <= rt[k] | (RW'(1) << B);
        end else begin
          rem_q <= rem[k];
          rt_q  <= rt[k];
        end
      end
    end
    assign rem[k+1] = rem_q;
    assign rt[k+1]  = rt_q;
  end
  assign root = rt[RW];
endmodule
`default_nettype wire

FILE: hw/rtl/v3au_merge.sv
// Merge: saturates a wide signed value to the component width.
`default_nettype none
module v3au_merge import v3au_pkg::*; #(
  parameter int W = CompWidth
) (
  input  wire logic signed [W+2:0] v,
  output logic signed [W-1:0]     sat
);
  localparam logic signed [W+2:0] MaxV = (W+3)'((64'sd1 <<< (W-1)) - 1);
  localparam logic signed [W+2:0] MinV = -(W+3)'(64'sd1 <<< (W-1));
  always_comb begin
    if (v > MaxV) sat = MaxV[W-1:0];
    else if (v < MinV) sat = MinV[W-1:0];
    else sat = v[W-1:0];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/vector3_arithmetic_unit.sv
// Top level: 3D vector add, subtract, dot, cross, scale and length.
//
// Input channel in/in_valid/in_stall carries one command with two vectors
// and a scale factor; output channel out/out_valid/out_stall carries one
// result per item. A transfer happens when valid is high and stall low.
// Items flow in a pipeline that advances whenever its last stage is empty
// or is being taken, so one item is accepted every cycle unless a stalled
// result waits in the last stage. The pipeline stages are the operand
// register, lane multipliers, sum, shift, and one stage per root bit of the
// length square root, which has COMPONENT_WIDTH + 2 bits; every command
// passes through all of them to keep order.
// Throughput: one item per cycle while the receiver does not stall, set by
// the lane multipliers and the square root pipeline, both fully pipelined.
// A receiver stall on a full last stage holds the whole pipeline and raises in_stall.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module vector3_arithmetic_unit import v3au_pkg::*; #(
  parameter int COMPONENT_WIDTH = CompWidth,
  parameter int FRACTION_BITS   = FracBits
) (
  input  wire             clk,
  input  wire             rst,
  input  wire in_item_t   in,
  input  wire             in_valid,
  output logic            in_stall,
  output out_item_t       out,
  output logic            out_valid,
  input  wire             out_stall
);
  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * W;
  localparam int SW = PW + 2;
  localparam int RW = W + 2;
  localparam int NW = 2 * RW;
  localparam int DEPTH = 4 + RW;

  logic adv;
  logic [DEPTH-1:0] vld;
  assign adv = !vld[DEPTH-1] || !out_stall;
  assign in_stall = !adv;

  // stage 0: operand register
  in_item_t s0;
  always_ff @(posedge clk) if (adv) s0 <= in;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[DEPTH-2:0], in_valid};
  end

  // lane operand selection per command
  logic signed [W-1:0] p0 [3], q0 [3], p1 [3], q1 [3];
  logic signed [W-1:0] ax, ay, az, bx, by, bz;
  assign ax = s0.a_x; assign ay = s0.a_y; assign az = s0.a_z;
  assign bx = s0.b_x; assign by = s0.b_y; assign bz = s0.b_z;
  always_comb begin
    p0[0] = ax; q0[0] = bx; p1[0] = ay; q1[0] = bz;
    p0[1] = ay; q0[1] = by; p1[1] = az; q1[1] = by;
    p0[2] = az; q0[2] = bz; p1[2] = ax; q1[2] = by;
    case (s0.command)
      CMD_CROSS: begin
        p0[0] = ay; q0[0] = bz; p1[0] = az; q1[0] = by;
        p0[1] = az; q0[1] = bx; p1[1] = ax; q1[1] = bz;
        p0[2] = ax; q0[2] = by; p1[2] = ay; q1[2] = bx;
      end
      CMD_SCALE: begin
        p0[0] = ax; q0[0] = s0.scale_factor;
        p0[1] = ay; q0[1] = s0.scale_factor;
        p0[2] = az; q0[2] = s0.scale_factor;
      end
      CMD_LEN: begin
        q0[0] = ax; q0[1] = ay; q0[2] = az;
        p0[0] = ax; p0[1] = ay; p0[2] = az;
      end
      default: ;
    endcase
  end

  logic signed [PW-1:0] m0 [3], m1 [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3au_lane #(.W(W)) u_lane (
      .clk(clk), .en(adv), .p0(p0[i]), .q0(q0[i]), .p1(p1[i]), .q1(q1[i]),
      .m0(m0[i]), .m1(m1[i])
    );
  end

  // stage 1 side data
  logic [2:0] cmd1;
  logic signed [W:0] as1 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= s0.command;
      as1[0] <= (s0.command == CMD_SUB) ? ((W+1)'(ax) - (W+1)'(bx)) : ((W+1)'(ax) + (W+1)'(bx));
      as1[1] <= (s0.command == CMD_SUB) ? ((W+1)'(ay) - (W+1)'(by)) : ((W+1)'(ay) + (W+1)'(by));
      as1[2] <= (s0.command == CMD_SUB) ? ((W+1)'(az) - (W+1)'(bz)) : ((W+1)'(az) + (W+1)'(bz));
    end
  end

  // stage 2: combine lane products, or align add and subtract results
  logic [2:0] cmd2;
  logic signed [SW-1:0] v2 [3];
  logic signed [SW-1:0] dot2;
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2 <= cmd1;
      dot2 <= SW'(m0[0]) + SW'(m0[1]) + SW'(m0[2]);
      for (int i = 0; i < 3; i++) begin
        case (cmd1)
          CMD_CROSS: v2[i] <= SW'(m0[i]) - SW'(m1[i]);
          CMD_SCALE: v2[i] <= SW'(m0[i]);
          default:   v2[i] <= SW'(as1[i]) <<< F;
        endcase
      end
    end
  end

  // stage 3: truncate toward zero
  function automatic logic signed [SW-1:0] fix(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] m;
    m = v[SW-1] ? -v : v;
    m = m >> F;
    return v[SW-1] ? -m : m;
  endfunction

  logic [2:0] cmd3;
  logic signed [SW-1:0] v3 [3];
  logic signed [SW-1:0] dot3;
  logic [NW-1:0] sq3;
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3 <= cmd2;
      dot3 <= fix(dot2);
      sq3  <= NW'(dot2[SW-2:0]);
      for (int i = 0; i < 3; i++) v3[i] <= fix(v2[i]);
    end
  end

  // square root pipeline and delay line for other results
  logic [RW-1:0] root;
  v3au_isqrt #(.NW(NW), .RW(RW)) u_sqrt (.clk(clk), .en(adv), .num(sq3), .root(root));

  logic [2:0] cmdd [RW+1];
  logic signed [W+2:0] vd [RW+1][3];
  logic signed [W+2:0] dd [RW+1];
  function automatic logic signed [W+2:0] clip(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] lim;
    lim = SW'(64'sd1) <<< W;
    if (v > lim) return (W+3)'(lim);
    if (v < -lim) return -(W+3)'(lim);
    return (W+3)'(v);
  endfunction
  always_comb begin
    cmdd[0] = cmd3;
    dd[0] = clip(dot3);
    for (int i = 0; i < 3; i++) vd[0][i] = clip(v3[i]);
  end
  for (genvar k = 0; k < RW; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        cmdd[k+1] <= cmdd[k];
        dd[k+1] <= dd[k];
        for (int i = 0; i < 3; i++) vd[k+1][i] <= vd[k][i];
      end
    end
  end

  // final saturation and output
  logic signed [W-1:0] sx, sy, sz, sd, sr;
  v3au_merge #(.W(W)) u_mx (.v(vd[RW][0]), .sat(sx));
  v3au_merge #(.W(W)) u_my (.v(vd[RW][1]), .sat(sy));
  v3au_merge #(.W(W)) u_mz (.v(vd[RW][2]), .sat(sz));
  v3au_merge #(.W(W)) u_md (.v(dd[RW]), .sat(sd));
  v3au_merge #(.W(W)) u_mr (.v((W+3)'({1'b0, root})), .sat(sr));

  always_comb begin
    out = '0;
    case (cmdd[RW])
      CMD_ADD, CMD_SUB, CMD_CROSS, CMD_SCALE: begin
        out.result_kind = KIND_VEC;
        out.res_x = CompWidth'(sx); out.res_y = CompWidth'(sy); out.res_z = CompWidth'(sz);
      end
      CMD_DOT: begin
        out.result_kind = KIND_SCL; out.res_scalar = CompWidth'(sd);
      end
      CMD_LEN: begin
        out.result_kind = KIND_SCL; out.res_scalar = CompWidth'(sr);
      end
      default: out.result_kind = KIND_ERR;
    endcase
  end
  assign out_valid = vld[DEPTH-1];

  // checks
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out)) else $error("output moved");
  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("stall while empty");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.result_kind == KIND_ERR |-> out.res_x == 0 && out.res_scalar == 0)
    else $error("error result not zero");
endmodule
`default_nettype wire

FILE: dv/vector3_arithmetic_unit_tb.sv
// Testbench for the 3D vector arithmetic unit: directed and random commands checked in order.
`timescale 1ns / 1ps
module vector3_arithmetic_unit_tb;
  import v3au_pkg::*;

  localparam int Latency = 4 + CompWidth + 2;
  localparam longint CycleLimit = 400000;

  logic clk;
  logic rst;
  in_item_t in;
  logic in_valid;
  logic in_stall;
  out_item_t out;
  logic out_valid;
  logic out_stall;

  out_item_t expected_results[$];
  int errors;
  int sent_count;
  int result_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  longint cycle_count;

  vector3_arithmetic_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in(in),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out(out),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Saturate a wide signed value to the 32-bit component range.
  function automatic logic signed [31:0] saturate(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Drop fraction bits, truncating toward zero.
  function automatic logic signed [127:0] drop_fraction(logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> FracBits;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic signed [127:0] mul_wide(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // Floor square root of a non-negative 128-bit value.
  function automatic logic [127:0] floor_root(logic [127:0] n);
    logic [127:0] root;
    logic [127:0] bitv;
    logic [127:0] trial;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0) begin
      trial = root + bitv;
      if (n >= trial) begin
        n = n - trial;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic out_item_t vector_result(in_item_t it);
    out_item_t r;
    logic signed [127:0] acc;
    logic [127:0] root;
    r = '0;
    r.result_kind = KIND_VEC;
    case (it.command)
      CMD_ADD: begin
        r.res_x = saturate(128'(it.a_x) + 128'(it.b_x));
        r.res_y = saturate(128'(it.a_y) + 128'(it.b_y));
        r.res_z = saturate(128'(it.a_z) + 128'(it.b_z));
      end
      CMD_SUB: begin
        r.res_x = saturate(128'(it.a_x) - 128'(it.b_x));
        r.res_y = saturate(128'(it.a_y) - 128'(it.b_y));
        r.res_z = saturate(128'(it.a_z) - 128'(it.b_z));
      end
      CMD_DOT: begin
        r.result_kind = KIND_SCL;
        acc = mul_wide(it.a_x, it.b_x) + mul_wide(it.a_y, it.b_y) + mul_wide(it.a_z, it.b_z);
        r.res_scalar = saturate(drop_fraction(acc));
      end
      CMD_CROSS: begin
        r.res_x = saturate(drop_fraction(mul_wide(it.a_y, it.b_z) - mul_wide(it.a_z, it.b_y)));
        r.res_y = saturate(drop_fraction(mul_wide(it.a_z, it.b_x) - mul_wide(it.a_x, it.b_z)));
        r.res_z = saturate(drop_fraction(mul_wide(it.a_x, it.b_y) - mul_wide(it.a_y, it.b_x)));
      end
      CMD_SCALE: begin
        r.res_x = saturate(drop_fraction(mul_wide(it.a_x, it.scale_factor)));
        r.res_y = saturate(drop_fraction(mul_wide(it.a_y, it.scale_factor)));
        r.res_z = saturate(drop_fraction(mul_wide(it.a_z, it.scale_factor)));
      end
      CMD_LEN: begin
        r.result_kind = KIND_SCL;
        acc = mul_wide(it.a_x, it.a_x) + mul_wide(it.a_y, it.a_y) + mul_wide(it.a_z, it.a_z);
        root = floor_root(acc);
        r.res_scalar = saturate($signed(root));
      end
      default: r.result_kind = KIND_ERR;
    endcase
    return r;
  endfunction

  // Offer one item; it stays put until the transfer happens.
  // Valid stays high after the transfer so the next item can follow directly.
  task automatic send_item(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(vector_result(it));
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_component();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(32'h0003ffff);
      3: return -$urandom_range(32'h0003ffff);
      4: return {{8{$urandom_range(1) == 1}}, 24'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.command = 3'($urandom_range(7));
    it.a_x = random_component();
    it.a_y = random_component();
    it.a_z = random_component();
    it.b_x = random_component();
    it.b_y = random_component();
    it.b_z = random_component();
    it.scale_factor = random_component();
    return it;
  endfunction

  // Receiver stall and long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out.result_kind !== exp_r.result_kind) begin
          $error("result_kind exp %0d got %0d", exp_r.result_kind, out.result_kind);
          errors++;
        end
        if (out.res_x !== exp_r.res_x) begin
          $error("res_x exp %0d got %0d", exp_r.res_x, out.res_x);
          errors++;
        end
        if (out.res_y !== exp_r.res_y) begin
          $error("res_y exp %0d got %0d", exp_r.res_y, out.res_y);
          errors++;
        end
        if (out.res_z !== exp_r.res_z) begin
          $error("res_z exp %0d got %0d", exp_r.res_z, out.res_z);
          errors++;
        end
        if (out.res_scalar !== exp_r.res_scalar) begin
          $error("res_scalar exp %0d got %0d", exp_r.res_scalar, out.res_scalar);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    in_item_t it;
    logic [31:0] ext[4];
    ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
    // Every command, including both invalid codes, on extreme operands.
    for (int c = 0; c < 8; c++) begin
      for (int k = 0; k < 3; k++) begin
        it.command = 3'(c);
        it.a_x = ext[k]; it.a_y = ext[(k + 1) % 4]; it.a_z = ext[(k + 2) % 4];
        it.b_x = ext[(k + 1) % 4]; it.b_y = ext[k]; it.b_z = ext[(k + 3) % 4];
        it.scale_factor = ext[k];
        send_item(it);
      end
    end
    // Small signed products that truncate toward zero, length of a unit vector.
    it = '0;
    it.command = CMD_SCALE; it.a_x = -32'sd3; it.a_y = 32'sd3; it.a_z = -32'sd1;
    it.scale_factor = 32'sh00008000;
    send_item(it);
    it = '0;
    it.command = CMD_LEN; it.a_x = 32'sh00010000;
    send_item(it);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item());
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_item(random_item());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    errors = 0;
    sent_count = 0;
    result_count = 0;
    hold_cycles = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 18;
    recv_idle_pct = 73;
    test_directed();
    test_random(600);
    send_idle_pct = 73;
    recv_idle_pct = 18;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(540);
    drain();

    $display("Covered %0d items and %0d results over all commands, extremes,",
             sent_count, result_count);
    $display("random stalls on both sides and a long receiver hold-off.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/v3au_pkg.sv
hw/rtl/v3au_lane.sv
hw/rtl/v3au_isqrt.sv
hw/rtl/v3au_merge.sv
hw/rtl/vector3_arithmetic_unit.sv
dv/vector3_arithmetic_unit_tb.sv
